[design/ssu_dpp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssu_dpp_pkg
// Shared widths and the result word type of the SSU data payload parser.
// ----------------------------------------------------------------------------
package ssu_dpp_pkg;

    localparam int BYTE_W      = 8;
    localparam int MSG_ID_W    = 32;
    localparam int FRAG_NUM_W  = 7;
    localparam int FRAG_SIZE_W = 14;
    localparam int INFO_W      = 24;
    localparam int COUNT_W     = 8;
    localparam int POS_W       = 3;

    // Bit positions inside the three-byte fragment info word
    localparam int INFO_NUM_LSB  = 17;
    localparam int INFO_LAST_BIT = 16;

    // Field byte counts
    localparam logic [POS_W-1:0] FIXED_BYTES = 3'd4;
    localparam logic [POS_W-1:0] INFO_BYTES  = 3'd3;

    // Master-side tdata width: result fields rounded up to whole bytes
    localparam int RES_BITS = MSG_ID_W + FRAG_NUM_W + 1 + FRAG_SIZE_W + BYTE_W + 1;
    localparam int TDATA_W  = ((RES_BITS + 7) / 8) * 8;

    // Result kinds
    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_DATA   = 1'b1;

    // One result word
    typedef struct packed {
        logic                   kind;
        logic [MSG_ID_W-1:0]    message_id;
        logic [FRAG_NUM_W-1:0]  fragment_number;
        logic                   last_fragment_of_message;
        logic [FRAG_SIZE_W-1:0] fragment_size;
        logic [BYTE_W-1:0]      data_byte;
        logic                   end_of_fragment;
        logic                   end_of_payload;
    } result_t;

endpackage

[design/ssu_dpp_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssu_dpp_parser
// Byte-wise payload parser: walks the flag byte, ack and field sections,
// gathers fragment headers and tags each fragment data byte.
// ----------------------------------------------------------------------------
module ssu_dpp_parser (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                byte_accept,
    input  logic [ssu_dpp_pkg::BYTE_W-1:0]      payload_byte,
    input  logic                                start_of_payload,
    output logic                                res_valid,
    output ssu_dpp_pkg::result_t                res_word
);
    import ssu_dpp_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_ACK_COUNT,
        PH_ACK_SKIP,
        PH_FIELD_COUNT,
        PH_FIELD_FIXED,
        PH_FIELD_VAR,
        PH_FRAG_COUNT,
        PH_MSG_ID,
        PH_FRAG_INFO,
        PH_DATA,
        PH_DONE
    } phase_t;

    phase_t                  phase_reg,     phase_next;
    logic [1:0]              flags_reg,     flags_next;
    logic [COUNT_W-1:0]      items_reg,     items_next;
    logic [POS_W-1:0]        pos_reg,       pos_next;
    logic [COUNT_W-1:0]      frags_reg,     frags_next;
    logic [MSG_ID_W-1:0]     msg_id_reg,    msg_id_next;
    logic [INFO_W-1:0]       info_reg,      info_next;
    logic [FRAG_SIZE_W-1:0]  data_left_reg, data_left_next;

    logic [POS_W-1:0]        pos_inc;
    logic [COUNT_W-1:0]      items_dec;
    logic [COUNT_W-1:0]      frags_dec;
    logic [FRAG_SIZE_W-1:0]  data_left_dec;
    logic [INFO_W-1:0]       info_shifted;
    logic                    eof;

    assign pos_inc       = pos_reg + 3'd1;
    assign items_dec     = items_reg - 8'd1;
    assign frags_dec     = frags_reg - 8'd1;
    assign data_left_dec = data_left_reg - 14'd1;
    assign info_shifted  = {info_reg[INFO_W-BYTE_W-1:0], payload_byte};
    assign eof           = (data_left_dec == '0);

    // Next state and result for the byte being accepted
    always_comb
    begin
        phase_next     = phase_reg;
        flags_next     = flags_reg;
        items_next     = items_reg;
        pos_next       = pos_reg;
        frags_next     = frags_reg;
        msg_id_next    = msg_id_reg;
        info_next      = info_reg;
        data_left_next = data_left_reg;
        res_valid      = 1'b0;

        res_word.kind                     = KIND_HEADER;
        res_word.message_id               = msg_id_reg;
        res_word.fragment_number          = info_reg[INFO_NUM_LSB +: FRAG_NUM_W];
        res_word.last_fragment_of_message = info_reg[INFO_LAST_BIT];
        res_word.fragment_size            = info_reg[FRAG_SIZE_W-1:0];
        res_word.data_byte                = '0;
        res_word.end_of_fragment          = 1'b0;
        res_word.end_of_payload           = 1'b0;

        if (byte_accept)
        begin
            if (start_of_payload)
            begin
                // Flag byte: restart whatever was in progress
                flags_next     = payload_byte[7:6];
                items_next     = '0;
                pos_next       = '0;
                frags_next     = '0;
                msg_id_next    = '0;
                info_next      = '0;
                data_left_next = '0;
                if (payload_byte[7])
                    phase_next = PH_ACK_COUNT;
                else if (payload_byte[6])
                    phase_next = PH_FIELD_COUNT;
                else
                    phase_next = PH_FRAG_COUNT;
            end
            else
            begin
                unique case (phase_reg)
                    PH_ACK_COUNT:
                    begin
                        items_next = payload_byte;
                        pos_next   = '0;
                        if (payload_byte != '0)
                            phase_next = PH_ACK_SKIP;
                        else
                            phase_next = flags_reg[0] ? PH_FIELD_COUNT : PH_FRAG_COUNT;
                    end
                    PH_ACK_SKIP:
                    begin
                        pos_next = pos_inc;
                        if (pos_inc >= FIXED_BYTES)
                        begin
                            pos_next   = '0;
                            items_next = items_dec;
                            if (items_dec == '0)
                                phase_next = flags_reg[0] ? PH_FIELD_COUNT : PH_FRAG_COUNT;
                        end
                    end
                    PH_FIELD_COUNT:
                    begin
                        items_next = payload_byte;
                        pos_next   = '0;
                        phase_next = (payload_byte == '0) ? PH_FRAG_COUNT : PH_FIELD_FIXED;
                    end
                    PH_FIELD_FIXED:
                    begin
                        pos_next = pos_inc;
                        if (pos_inc >= FIXED_BYTES)
                        begin
                            pos_next   = '0;
                            phase_next = PH_FIELD_VAR;
                        end
                    end
                    PH_FIELD_VAR:
                    begin
                        // Variable part ends at the first byte with bit 7 clear
                        if (!payload_byte[7])
                        begin
                            items_next = items_dec;
                            phase_next = (items_dec == '0) ? PH_FRAG_COUNT : PH_FIELD_FIXED;
                        end
                    end
                    PH_FRAG_COUNT:
                    begin
                        frags_next = payload_byte;
                        if (payload_byte == '0)
                            phase_next = PH_DONE;
                        else
                        begin
                            phase_next  = PH_MSG_ID;
                            pos_next    = '0;
                            msg_id_next = '0;
                        end
                    end
                    PH_MSG_ID:
                    begin
                        msg_id_next = {msg_id_reg[MSG_ID_W-BYTE_W-1:0], payload_byte};
                        pos_next    = pos_inc;
                        if (pos_inc >= FIXED_BYTES)
                        begin
                            pos_next   = '0;
                            info_next  = '0;
                            phase_next = PH_FRAG_INFO;
                        end
                    end
                    PH_FRAG_INFO:
                    begin
                        info_next = info_shifted;
                        pos_next  = pos_inc;
                        if (pos_inc >= INFO_BYTES)
                        begin
                            // Header complete: give the header word
                            pos_next       = '0;
                            frags_next     = frags_dec;
                            data_left_next = info_shifted[FRAG_SIZE_W-1:0];
                            res_valid      = 1'b1;
                            res_word.fragment_number =
                                info_shifted[INFO_NUM_LSB +: FRAG_NUM_W];
                            res_word.last_fragment_of_message =
                                info_shifted[INFO_LAST_BIT];
                            res_word.fragment_size = info_shifted[FRAG_SIZE_W-1:0];
                            if (info_shifted[FRAG_SIZE_W-1:0] == '0)
                            begin
                                // Empty fragment
                                res_word.end_of_fragment = 1'b1;
                                res_word.end_of_payload  = (frags_dec == '0);
                                if (frags_dec == '0)
                                    phase_next = PH_DONE;
                                else
                                begin
                                    phase_next  = PH_MSG_ID;
                                    msg_id_next = '0;
                                end
                            end
                            else
                                phase_next = PH_DATA;
                        end
                    end
                    PH_DATA:
                    begin
                        data_left_next           = data_left_dec;
                        res_valid                = 1'b1;
                        res_word.kind            = KIND_DATA;
                        res_word.data_byte       = payload_byte;
                        res_word.end_of_fragment = eof;
                        res_word.end_of_payload  = eof && (frags_reg == '0);
                        if (eof)
                        begin
                            if (frags_reg == '0)
                                phase_next = PH_DONE;
                            else
                            begin
                                phase_next  = PH_MSG_ID;
                                pos_next    = '0;
                                msg_id_next = '0;
                            end
                        end
                    end
                    default:
                    begin
                        // Idle or done: byte ignored
                    end
                endcase
            end
        end
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            flags_reg     <= '0;
            items_reg     <= '0;
            pos_reg       <= '0;
            frags_reg     <= '0;
            msg_id_reg    <= '0;
            info_reg      <= '0;
            data_left_reg <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            flags_reg     <= flags_next;
            items_reg     <= items_next;
            pos_reg       <= pos_next;
            frags_reg     <= frags_next;
            msg_id_reg    <= msg_id_next;
            info_reg      <= info_next;
            data_left_reg <= data_left_next;
        end
    end

endmodule

[design/ssu_dpp_out_skid.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssu_dpp_out_skid
// Result register with one skid word, so the input side keeps running
// while a result waits on the master side.
// ----------------------------------------------------------------------------
module ssu_dpp_out_skid (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  ssu_dpp_pkg::result_t in_word,
    output logic                 in_ready,
    output logic                 out_valid,
    output ssu_dpp_pkg::result_t out_word,
    input  logic                 out_ready
);
    import ssu_dpp_pkg::*;

    logic    out_valid_reg,  out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_word_reg,   out_word_next;
    result_t skid_word_reg,  skid_word_next;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // Refill the output word from skid first, then from the parser
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_word_next   = out_word_reg;
        skid_word_next  = skid_word_reg;
        if (out_ready || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_word_next   = skid_word_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = in_valid;
                out_word_next  = in_word;
            end
        end
        else if (in_valid)
        begin
            skid_valid_next = 1'b1;
            skid_word_next  = in_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload words
    always_ff @(posedge clk)
    begin
        out_word_reg  <= out_word_next;
        skid_word_reg <= skid_word_next;
    end

endmodule

[design/ssu_data_payload_parser_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssu_data_payload_parser_unit
// SSU data payload parser: bytes in, fragment header and data words out.
// ----------------------------------------------------------------------------
// Takes one payload byte per cycle on the slave side while s_axis_tready is
// high; tuser high marks the flag byte of a new payload and restarts parsing
// at once. Ack and field sections are skipped, and each fragment gives one
// header word (tuser 0) followed by one word per data byte (tuser 1); tlast
// marks the last word of the payload. A result is registered in the result
// register, passing through the skid word first while the master side stalls.
// The sustained rate is one byte per cycle; s_axis_tready falls only when the
// result register and its skid word are both full.
module ssu_data_payload_parser_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [7:0] payload_byte
    input  logic [ssu_dpp_pkg::BYTE_W-1:0]   s_axis_tdata,
    // [0] start_of_payload
    input  logic                             s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [31:0] message_id, [38:32] fragment_number,
    // [39] last_fragment_of_message, [53:40] fragment_size,
    // [61:54] data_byte, [62] end_of_fragment, [63] zero
    output logic [ssu_dpp_pkg::TDATA_W-1:0]  m_axis_tdata,
    // [0] result_kind
    output logic                             m_axis_tuser,
    // end_of_payload
    output logic                             m_axis_tlast
);
    import ssu_dpp_pkg::*;

    logic    byte_accept;
    logic    res_valid;
    result_t res_word;
    result_t out_word;

    assign byte_accept = s_axis_tvalid && s_axis_tready;

    // Parser
    ssu_dpp_parser u_parser (
        .clk              (clk),
        .rst_n            (rst_n),
        .byte_accept      (byte_accept),
        .payload_byte     (s_axis_tdata),
        .start_of_payload (s_axis_tuser),
        .res_valid        (res_valid),
        .res_word         (res_word)
    );

    // Result register and skid word
    ssu_dpp_out_skid u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (res_valid),
        .in_word   (res_word),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_word  (out_word),
        .out_ready (m_axis_tready)
    );

    // Pack the master-side word
    assign m_axis_tdata = {
        {(TDATA_W - RES_BITS){1'b0}},
        out_word.end_of_fragment,
        out_word.data_byte,
        out_word.fragment_size,
        out_word.last_fragment_of_message,
        out_word.fragment_number,
        out_word.message_id
    };
    assign m_axis_tuser = out_word.kind;
    assign m_axis_tlast = out_word.end_of_payload;

endmodule
